[src/aot_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aot_pkg: shared types and helpers for the box overlap table
// Beat formats, opcodes, controller states, coordinate saturation and the
// per-entry overlap test.
// ----------------------------------------------------------------------------
package aot_pkg;

	localparam int TABLE_DEPTH = 2048;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int POS_W       = 6;
	localparam int GROUP_SIZE  = 1 << POS_W;
	localparam int GRP_W       = 5;
	localparam int TOT_W       = POS_W + 1;

	// empty entry word: min 32767, negated max 32767 (max -32767)
	localparam logic signed [15:0] EMPTY_WORD = 16'sh7fff;
	localparam logic signed [15:0] COORD_LOW  = 16'sh8000;

	typedef logic signed [15:0] coord_t;

	typedef enum logic [1:0] {
		OP_SET       = 2'd0,
		OP_CLEAR     = 2'd1,
		OP_CLEAR_ALL = 2'd2,
		OP_QUERY     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t                opcode;
		logic [ADDR_W-1:0]  slot;
		logic signed [31:0] lo_x;
		logic signed [31:0] lo_y;
		logic signed [31:0] lo_z;
		logic signed [31:0] hi_x;
		logic signed [31:0] hi_y;
		logic signed [31:0] hi_z;
	} req_t;

	typedef struct packed {
		logic [GRP_W-1:0] group;
		logic [63:0]      hit_mask;
		logic [TOT_W-1:0] hit_total;
		logic             last;
	} rsp_t;

	// one table entry: minimums and negated maximums, 96 bits
	typedef struct packed {
		coord_t mn_x;
		coord_t mn_y;
		coord_t mn_z;
		coord_t nmx_x;
		coord_t nmx_y;
		coord_t nmx_z;
	} box_t;

	localparam box_t EMPTY_BOX = '{EMPTY_WORD, EMPTY_WORD, EMPTY_WORD,
		EMPTY_WORD, EMPTY_WORD, EMPTY_WORD};

	// minimum clamped to [-32768, 32767]
	function automatic coord_t sat_lo(logic signed [31:0] v);
		if (v < -32'sd32768)
			return COORD_LOW;
		else if (v > 32'sd32767)
			return EMPTY_WORD;
		else
			return v[15:0];
	endfunction

	// maximum clamped to [-32767, 32768], then negated
	function automatic coord_t sat_neg_hi(logic signed [31:0] v);
		logic signed [31:0] n;
		n = -v;
		if (v > 32'sd32767)
			return COORD_LOW;
		else if (v < -32'sd32767)
			return EMPTY_WORD;
		else
			return n[15:0];
	endfunction

	function automatic box_t make_box(req_t r);
		box_t b;
		b.mn_x  = sat_lo(r.lo_x);
		b.mn_y  = sat_lo(r.lo_y);
		b.mn_z  = sat_lo(r.lo_z);
		b.nmx_x = sat_neg_hi(r.hi_x);
		b.nmx_y = sat_neg_hi(r.hi_y);
		b.nmx_z = sat_neg_hi(r.hi_z);
		return b;
	endfunction

	// min <= max  <=>  min + negmax <= 0
	function automatic logic le_zero(coord_t a, coord_t b);
		logic signed [16:0] s;
		s = {a[15], a} + {b[15], b};
		return s[16] || (s == 17'sd0);
	endfunction

	function automatic logic box_hit(box_t e, box_t q);
		return le_zero(q.mn_x, e.nmx_x) && le_zero(e.mn_x, q.nmx_x) &&
			le_zero(q.mn_y, e.nmx_y) && le_zero(e.mn_y, q.nmx_y) &&
			le_zero(q.mn_z, e.nmx_z) && le_zero(e.mn_z, q.nmx_z);
	endfunction

endpackage

[src/aabb_overlap_table_query.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_overlap_table_query: box table with overlap query
// Holds TABLE_DEPTH boxes in one memory; a query walks used entries one per
// cycle within a group via a single overlap comparator into 64-bit hit masks.
// ----------------------------------------------------------------------------
// Set and clear write the entry as they are accepted; clear all sweeps the
// entries below used_count to empty with req_stall high. A query returns
// ceil(used/64) mask beats (at least one); for each beat it scans a group
// through the single memory read port into one comparator, then passes a
// drain and a hand-off state, where a finished beat waits on rsp_stall.
// Reset: after arst_n releases, the block sweeps all 2048 entries to empty,
// one per cycle, with req_stall high; used_count resets to zero.

module aabb_overlap_table_query import aot_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	state_t state_q, state_d;

	// box memory, one write port and one registered read port
	box_t mem [TABLE_DEPTH];
	box_t rd_data_s1;
	logic mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	box_t mem_wdata;

	logic [CNT_W-1:0] used_q;      // one past the highest slot set since clear all
	logic [CNT_W-1:0] clr_q;       // sweep pointer
	logic [CNT_W-1:0] clr_lim_q;   // sweep end
	logic [CNT_W-1:0] scan_q;      // next entry to read
	logic             pend_s1;     // read data valid for compare
	logic             inr_s1;      // entry below used count
	logic [POS_W-1:0] pos_s1;      // mask bit of the entry

	box_t             qbox_q;      // saturated query box
	logic [63:0]      mask_q;
	logic [TOT_W-1:0] tot_q;
	logic [GRP_W-1:0] grp_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	logic req_acc;
	logic load_rsp;
	logic last_grp;
	logic sweep_done;
	logic [CNT_W-1:0] slot_next;

	assign req_acc    = req_valid && !req_stall;
	assign last_grp   = scan_q >= used_q;
	assign sweep_done = clr_q == clr_lim_q;
	assign slot_next  = {1'b0, req.slot} + CNT_W'(1);

	// ---------------------------------------------------------------------
	// controller
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_SWEEP;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = clr_q[ADDR_W-1:0];
		mem_wdata = EMPTY_BOX;
		load_rsp  = 1'b0;
		unique case (state_q)
			ST_SWEEP: begin
				if (sweep_done)
					state_d = ST_IDLE;
				else
					mem_we = 1'b1;
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					unique case (req.opcode)
						OP_SET: begin
							mem_we    = 1'b1;
							mem_waddr = req.slot;
							mem_wdata = make_box(req);
						end
						OP_CLEAR: begin
							mem_we    = 1'b1;
							mem_waddr = req.slot;
						end
						OP_CLEAR_ALL: state_d = ST_SWEEP;
						OP_QUERY:     state_d = ST_SCAN;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				// last entry of the group issued this cycle
				if (scan_q[POS_W-1:0] == {POS_W{1'b1}})
					state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_OUT;
			ST_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_rsp = 1'b1;
					state_d  = last_grp ? ST_IDLE : ST_SCAN;
				end
			end
			default: state_d = ST_SWEEP;
		endcase
	end

	// ---------------------------------------------------------------------
	// memory
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_data_s1 <= mem[scan_q[ADDR_W-1:0]];
	end

	// ---------------------------------------------------------------------
	// counters
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			clr_q     <= '0;
			clr_lim_q <= CNT_W'(TABLE_DEPTH);
			scan_q    <= '0;
			pend_s1   <= 1'b0;
			inr_s1    <= 1'b0;
			pos_s1    <= '0;
		end else begin
			pend_s1 <= state_q == ST_SCAN;
			inr_s1  <= scan_q < used_q;
			pos_s1  <= scan_q[POS_W-1:0];
			if (state_q == ST_SCAN)
				scan_q <= scan_q + CNT_W'(1);
			if (state_q == ST_SWEEP) begin
				if (sweep_done)
					used_q <= '0;
				else
					clr_q <= clr_q + CNT_W'(1);
			end
			if (req_acc) begin
				case (req.opcode)
					OP_SET: begin
						if (used_q < slot_next)
							used_q <= slot_next;
					end
					OP_CLEAR_ALL: begin
						// everything at or above used_q is already empty
						clr_q     <= '0;
						clr_lim_q <= used_q;
					end
					OP_QUERY: scan_q <= '0;
					default: ;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------------
	// overlap compare and mask build
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (req_acc && req.opcode == OP_QUERY) begin
			qbox_q <= make_box(req);
			mask_q <= '0;
			tot_q  <= '0;
			grp_q  <= '0;
		end else if (load_rsp) begin
			mask_q <= '0;
			tot_q  <= '0;
			grp_q  <= grp_q + GRP_W'(1);
		end else if (pend_s1 && inr_s1 && box_hit(rd_data_s1, qbox_q)) begin
			mask_q[pos_s1] <= 1'b1;
			tot_q          <= tot_q + TOT_W'(1);
		end
	end

	// ---------------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (load_rsp)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.group     <= grp_q;
			rsp_q.hit_mask  <= mask_q;
			rsp_q.hit_total <= tot_q;
			rsp_q.last      <= last_grp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[src/aot_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aot_checker: port-level checks for the box overlap table
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module aot_checker import aot_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed under stall");

	// total matches mask
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.hit_total == $countones(rsp.hit_mask))
		else $error("hit_total does not match hit_mask");

	// the top group always ends a query
	a_top_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.group == GRP_W'(TABLE_DEPTH / GROUP_SIZE - 1) |-> rsp.last)
		else $error("top group without last");

	// a query keeps the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.opcode == OP_QUERY |=> req_stall)
		else $error("request taken during query");

endmodule

bind aabb_overlap_table_query aot_checker u_aot_checker (.*);

[tb/aabb_overlap_table_query_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_overlap_table_query_tb: self-checking bench for the box overlap table
// Drives set, clear, clear-all and query beats with random gaps. A mirror of
// the box table predicts every hit-mask beat, and each returned beat is
// compared field by field in arrival order.
// ----------------------------------------------------------------------------
module aabb_overlap_table_query_tb;
	import aot_pkg::*;

	localparam int IDLE_LIMIT   = 20000;   // cycles with no beat on either side
	localparam int TAIL_CYCLES  = 2200;    // covers a clear-all over a full table
	localparam int RANDOM_ITEMS = 250;
	localparam int I32_MIN      = 32'sh8000_0000;
	localparam int I32_MAX      = 32'sh7fff_ffff;

	// Mirror of the box table. Keeps minimums and negated maximums per axis,
	// the used-entry count, and the hit-mask beats that queries still owe.
	class box_table_mirror;
		logic signed [15:0] lo_tab [TABLE_DEPTH][3];
		logic signed [15:0] nhi_tab [TABLE_DEPTH][3];
		int unsigned        fill;
		rsp_t               masks_due[$];
		int                 errors;

		function new();
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			for (int e = 0; e < TABLE_DEPTH; e++) begin
				for (int a = 0; a < 3; a++) begin
					lo_tab[e][a]  = EMPTY_WORD;
					nhi_tab[e][a] = EMPTY_WORD;
				end
			end
			fill = 0;
		endfunction

		static function int clamp(int v, int lo, int hi);
			if (v < lo)
				return lo;
			if (v > hi)
				return hi;
			return v;
		endfunction

		// inclusive overlap on all three axes
		function bit hits(int e, int qlo[3], int qhi[3]);
			int emin;
			int emax;
			for (int a = 0; a < 3; a++) begin
				emin = int'(lo_tab[e][a]);
				emax = -int'(nhi_tab[e][a]);
				if (qlo[a] > emax || qhi[a] < emin)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void apply_request(req_t r);
			int          qlo[3];
			int          qhi[3];
			int          groups;
			int          e;
			logic [63:0] mask;
			rsp_t        beat;
			qlo[0] = clamp(r.lo_x, -32768, 32767);
			qlo[1] = clamp(r.lo_y, -32768, 32767);
			qlo[2] = clamp(r.lo_z, -32768, 32767);
			qhi[0] = clamp(r.hi_x, -32767, 32768);
			qhi[1] = clamp(r.hi_y, -32767, 32768);
			qhi[2] = clamp(r.hi_z, -32767, 32768);
			case (r.opcode)
				OP_SET: begin
					for (int a = 0; a < 3; a++) begin
						lo_tab[r.slot][a]  = 16'(qlo[a]);
						nhi_tab[r.slot][a] = 16'(-qhi[a]);
					end
					if (fill < int'(r.slot) + 1)
						fill = int'(r.slot) + 1;
				end
				OP_CLEAR: begin
					for (int a = 0; a < 3; a++) begin
						lo_tab[r.slot][a]  = EMPTY_WORD;
						nhi_tab[r.slot][a] = EMPTY_WORD;
					end
				end
				OP_CLEAR_ALL: begin
					wipe();
				end
				OP_QUERY: begin
					// an empty table still answers with one all-zero beat
					groups = (fill == 0) ? 1 : (fill + 63) / 64;
					for (int g = 0; g < groups; g++) begin
						mask = '0;
						for (int k = 0; k < GROUP_SIZE; k++) begin
							e = g * GROUP_SIZE + k;
							if (e < fill && hits(e, qlo, qhi))
								mask[k] = 1'b1;
						end
						beat.group     = GRP_W'(g);
						beat.hit_mask  = mask;
						beat.hit_total = TOT_W'($countones(mask));
						beat.last      = (g == groups - 1);
						masks_due.push_back(beat);
					end
				end
			endcase
		endfunction

		function void check_mask_beat(rsp_t got);
			rsp_t exp;
			bit   bad;
			if (masks_due.size() == 0) begin
				$display("%0t: unexpected mask beat group %0d mask %h", $time,
					got.group, got.hit_mask);
				errors++;
				return;
			end
			exp = masks_due.pop_front();
			bad = 1'b0;
			if (got.group !== exp.group) begin
				$display("%0t: group expected %0d actual %0d", $time, exp.group, got.group);
				bad = 1'b1;
			end
			if (got.hit_mask !== exp.hit_mask) begin
				$display("%0t: hit_mask expected %h actual %h", $time,
					exp.hit_mask, got.hit_mask);
				bad = 1'b1;
			end
			if (got.hit_total !== exp.hit_total) begin
				$display("%0t: hit_total expected %0d actual %0d", $time,
					exp.hit_total, got.hit_total);
				bad = 1'b1;
			end
			if (got.last !== exp.last) begin
				$display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
				bad = 1'b1;
			end
			if (bad)
				errors++;
		endfunction

		function int pending();
			return masks_due.size();
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	box_table_mirror mirror = new();

	bit send_calm = 1'b0;   // no gaps between request beats
	bit take_calm = 1'b0;   // no stalls on the mask side
	int idle_cycles = 0;

	aabb_overlap_table_query dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitor: beats are sampled at the edge that accepts them. Mask beats are
	// checked before a new request is folded in; a query cannot answer in the
	// same cycle it is taken, so the order here never matters for a match.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				mirror.check_mask_beat(rsp);
			if (req_valid && !req_stall)
				mirror.apply_request(req);
		end
	end

	// Watchdog on progress. The longest legal quiet stretch is the reset sweep
	// or a full clear-all plus a long stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Gap before a request beat: mostly none or short, now and then long.
	function automatic int sender_gap();
		int w;
		if (send_calm)
			return 0;
		w = $urandom_range(0, 99);
		if (w < 50)
			return 0;
		if (w < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Stall hold on the mask side. The next beat follows a group scan, a drain
	// and a hand-off; the mid band is sized to land on it, the long band spans several.
	function automatic int stall_hold();
		int w;
		if (take_calm)
			return 0;
		w = $urandom_range(0, 99);
		if (w < 45)
			return 0;
		if (w < 75)
			return $urandom_range(1, 4);
		if (w < 90)
			return $urandom_range(55, 80);
		return $urandom_range(100, 300);
	endfunction

	// Mask-side stall: a hold starts after each taken mask beat and after each
	// taken query, so stalls fall before the first beat and between beats.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if ((rsp_valid && !rsp_stall) ||
				(req_valid && !req_stall && req.opcode == OP_QUERY)) begin
				n = stall_hold();
				if (n > 0) begin
					rsp_stall <= 1'b1;
					repeat (n) @(posedge clk);
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	function automatic req_t make_req(op_t op, int slot, int lx, int ly, int lz,
		int hx, int hy, int hz);
		req_t r;
		r.opcode = op;
		r.slot   = ADDR_W'(slot);
		r.lo_x   = lx;
		r.lo_y   = ly;
		r.lo_z   = lz;
		r.hi_x   = hx;
		r.hi_y   = hy;
		r.hi_z   = hz;
		return r;
	endfunction

	// same extent on all three axes
	function automatic req_t cube(op_t op, int slot, int lo, int hi);
		return make_req(op, slot, lo, lo, lo, hi, hi, hi);
	endfunction

	// values around both saturation limits and the 32-bit ends
	function automatic int boundary_coord();
		int picks[10] = '{I32_MIN, -32769, -32768, -32767, -1, 0, 32767, 32768, 32769,
			I32_MAX};
		return picks[$urandom_range(0, 9)];
	endfunction

	// One axis of a random box. Mostly small boxes near the origin so that
	// queries get partial masks; some at the limits, some raw 32-bit noise,
	// some inverted, some wide (from -30000 or below to 30000 or above).
	function automatic void rand_span(output int lo, output int hi);
		case ($urandom_range(0, 9))
			6: begin
				lo = boundary_coord();
				hi = boundary_coord();
			end
			7: begin
				lo = int'($urandom);
				hi = int'($urandom);
			end
			8: begin
				hi = int'($urandom_range(0, 400)) - 200;
				lo = hi + int'($urandom_range(1, 50));
			end
			9: begin
				lo = -int'($urandom_range(30000, 70000));
				hi = int'($urandom_range(30000, 70000));
			end
			default: begin
				lo = int'($urandom_range(0, 400)) - 200;
				hi = lo + int'($urandom_range(0, 120));
			end
		endcase
	endfunction

	function automatic req_t random_req(op_t op, int span);
		int lx, ly, lz, hx, hy, hz;
		rand_span(lx, hx);
		rand_span(ly, hy);
		rand_span(lz, hz);
		return make_req(op, $urandom_range(0, span), lx, ly, lz, hx, hy, hz);
	endfunction

	// Called right after an edge. Valid stays high across back-to-back beats
	// and is only lowered when a gap is drawn.
	task automatic push_req(req_t r);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// Hold the request side until every owed mask beat has come back.
	// Polled on the falling edge so the monitor has settled.
	task automatic await_results();
		req_valid <= 1'b0;
		do
			@(negedge clk);
		while (mirror.pending() != 0);
		@(posedge clk);
	endtask

	initial begin
		int   sent;
		int   span;
		int   burst;
		int   w;
		op_t  op;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-table query, saturation at both ends, inverted and
		// empty-pattern boxes, inclusive touching, group edges, full table.
		push_req(cube(OP_QUERY, 0, I32_MIN, I32_MAX));
		push_req(cube(OP_SET, 0, I32_MIN, I32_MAX));
		push_req(cube(OP_SET, 1, I32_MAX, I32_MIN));
		push_req(cube(OP_SET, 2, -32768, 32768));
		push_req(cube(OP_SET, 3, 32767, -32767));
		push_req(make_req(OP_SET, 5, 20, -5, 100, 30, 5, 100));
		push_req(cube(OP_SET, 6, -32769, 32769));
		push_req(cube(OP_CLEAR, 1, 0, 0));
		// slot 4 was never written: it reads as empty and must still report
		push_req(cube(OP_QUERY, 0, I32_MIN, I32_MAX));
		push_req(cube(OP_QUERY, 0, -32767, 32767));     // just reaches empty entries
		push_req(cube(OP_QUERY, 0, -32766, 32767));     // just misses them
		push_req(make_req(OP_QUERY, 1234, 30, 5, 100, 40, 9, 100));  // edge contact
		push_req(cube(OP_QUERY, 0, 10, -10));
		push_req(cube(OP_SET, 63, -3, 3));
		push_req(cube(OP_QUERY, 0, 0, 0));
		push_req(cube(OP_SET, 64, 2, 9));
		push_req(cube(OP_QUERY, 0, 3, 5));
		push_req(cube(OP_SET, 2047, -1, 1));
		push_req(cube(OP_QUERY, 0, 0, 0));
		push_req(cube(OP_CLEAR, 2047, 0, 0));            // count stays at full depth
		push_req(cube(OP_QUERY, 0, I32_MIN, I32_MAX));
		push_req(cube(OP_CLEAR_ALL, 0, 0, 0));
		push_req(cube(OP_QUERY, 0, I32_MIN, I32_MAX));
		push_req(random_req(OP_SET, 2047));
		push_req(random_req(OP_QUERY, 2047));
		await_results();

		// Random scenes: usually start from a cleared table, fill a span of
		// slots and query against it. Most spans are small to keep scans
		// short; one scene in ten uses the whole table.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 3)
				await_results();
			send_calm = ($urandom_range(0, 5) == 0);
			take_calm = ($urandom_range(0, 5) == 0);
			span = ($urandom_range(0, 9) == 0) ? TABLE_DEPTH - 1 : $urandom_range(8, 200);
			if ($urandom_range(0, 9) < 7) begin
				push_req(random_req(OP_CLEAR_ALL, span));
				sent++;
			end
			burst = $urandom_range(15, 40);
			repeat (burst) begin
				w = $urandom_range(0, 99);
				if (w < 50)
					op = OP_SET;
				else if (w < 62)
					op = OP_CLEAR;
				else if (w < 64)
					op = OP_CLEAR_ALL;
				else
					op = OP_QUERY;
				push_req(random_req(op, span));
				sent++;
			end
		end
		req_valid <= 1'b0;
		take_calm = 1'b0;

		while (mirror.pending() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mirror.errors == 0 && mirror.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
